FILE: sv/sapq_pkg.sv
// Shared constants, codes and controller/datapath interface types for the priority queue.
package sapq_pkg;

  localparam int QUEUE_DEPTH = 128;
  localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int DATA_W      = 32;
  localparam int PRIO_W      = 16;
  localparam int FUNC_W      = 2;
  localparam int STATUS_W    = 2;

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_ENQUEUE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_DEQUEUE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_FRONT   = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

  // Commands from controller to datapath
  typedef struct packed {
    logic                load_in;    // capture item, set scan index to tail
    logic                rd_en;      // issue a memory read
    logic                rd_head;    // read at head instead of scan index
    logic                idx_dec;    // step scan index down and read there
    logic                wr_en;      // issue a memory write
    logic                wr_new;     // write the new entry (else the read entry)
    logic                wr_head;    // write at head (else one past scan index)
    logic                cnt_inc;    // one entry added
    logic                cnt_dec;    // head entry removed
    logic                res_set;    // record the result
    logic [STATUS_W-1:0] res_status;
    logic                res_head;   // result carries the read entry
    logic                out_load;   // move result into the output register
  } sapq_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic count_zero;
    logic count_full;
    logic cmp_le;     // read priority <= new priority
    logic idx_zero;
  } sapq_stat_t;

  // Map a logical position to a memory address in the circular store
  function automatic logic [ADDR_W-1:0] phys_addr(input logic [ADDR_W-1:0] head,
                                                   input logic [ADDR_W-1:0] offs);
    logic [ADDR_W:0] sum;
    sum = {1'b0, head} + {1'b0, offs};
    if (sum >= (ADDR_W + 1)'(QUEUE_DEPTH)) begin
      sum = sum - (ADDR_W + 1)'(QUEUE_DEPTH);
    end
    return sum[ADDR_W-1:0];
  endfunction

endpackage

FILE: sv/sorted_array_priority_queue_top.sv
// Top level of the sorted-array priority queue: controller plus datapath.
//
// Input channel (in_valid/in_ready) carries func, item_data, item_priority:
// enqueue, dequeue head, or read head. Output channel (out_valid/out_ready)
// returns exactly one result item per input item: status, head_data and
// head_priority (zero unless a read head succeeds).
// Entries live in a circular single-port-style store (one write and one
// registered read per cycle) with a head pointer, so a dequeue only moves
// the head. An enqueue scans from the tail toward the head, moving one entry
// per cycle one place back until it meets a higher priority.
// Dequeue, errors and unused codes go straight to the result; read head
// first reads the head entry, an enqueue into an empty queue writes it at
// once, and other enqueues first scan, so their time grows with entries moved.
// One item is in work at a time; a new item is taken once the previous
// result sits in the output register, so a stalled receiver holds that
// result and the next item's finished one, then blocks new items.
// Reset (rst, synchronous) empties the queue and drops any pending result;
// the store contents are not cleared and need not be.
module sorted_array_priority_queue_top (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic        [sapq_pkg::FUNC_W-1:0]    func,
  input  logic signed [sapq_pkg::DATA_W-1:0]    item_data,
  input  logic signed [sapq_pkg::PRIO_W-1:0]    item_priority,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic        [sapq_pkg::STATUS_W-1:0]  status,
  output logic signed [sapq_pkg::DATA_W-1:0]    head_data,
  output logic signed [sapq_pkg::PRIO_W-1:0]    head_priority
);
  import sapq_pkg::*;

  sapq_cmd_t  cmd;
  sapq_stat_t stat;

  sapq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sapq_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .item_data     (item_data),
    .item_priority (item_priority),
    .cmd           (cmd),
    .stat          (stat),
    .status        (status),
    .head_data     (head_data),
    .head_priority (head_priority)
  );

endmodule

FILE: sv/sapq_dp.sv
// Datapath: entry store, head/count/index registers, comparator and result registers.
module sapq_dp (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic signed [sapq_pkg::DATA_W-1:0]    item_data,
  input  logic signed [sapq_pkg::PRIO_W-1:0]    item_priority,
  input  sapq_pkg::sapq_cmd_t                   cmd,
  output sapq_pkg::sapq_stat_t                  stat,
  output logic        [sapq_pkg::STATUS_W-1:0]  status,
  output logic signed [sapq_pkg::DATA_W-1:0]    head_data,
  output logic signed [sapq_pkg::PRIO_W-1:0]    head_priority
);
  import sapq_pkg::*;

  logic        [DATA_W-1:0]   data_mem [QUEUE_DEPTH];
  logic        [PRIO_W-1:0]   prio_mem [QUEUE_DEPTH];

  logic signed [DATA_W-1:0]   new_data;
  logic signed [PRIO_W-1:0]   new_prio;
  logic        [DATA_W-1:0]   rd_data;
  logic        [PRIO_W-1:0]   rd_prio;
  logic        [ADDR_W-1:0]   idx;
  logic        [ADDR_W-1:0]   head;
  logic        [CNT_W-1:0]    count;
  logic        [STATUS_W-1:0] res_status;
  logic        [DATA_W-1:0]   res_data;
  logic        [PRIO_W-1:0]   res_prio;

  logic        [ADDR_W-1:0]   idx_next;
  logic        [ADDR_W-1:0]   rd_addr;
  logic        [ADDR_W-1:0]   wr_addr;
  logic        [DATA_W-1:0]   wr_data;
  logic        [PRIO_W-1:0]   wr_prio;

  // Pick read and write addresses and the write source
  always_comb begin
    idx_next = cmd.idx_dec ? idx - ADDR_W'(1) : idx;
    rd_addr  = cmd.rd_head ? head : phys_addr(head, idx_next);
    wr_addr  = cmd.wr_head ? head : phys_addr(head, idx + ADDR_W'(1));
    wr_data  = cmd.wr_new ? new_data : rd_data;
    wr_prio  = cmd.wr_new ? new_prio : rd_prio;
  end

  // Entry store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      data_mem[wr_addr] <= wr_data;
      prio_mem[wr_addr] <= wr_prio;
    end
    if (cmd.rd_en) begin
      rd_data <= data_mem[rd_addr];
      rd_prio <= prio_mem[rd_addr];
    end
  end

  // Hold the item and the scan index
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      new_data <= item_data;
      new_prio <= item_priority;
      idx      <= ADDR_W'(count - CNT_W'(1));
    end else if (cmd.idx_dec) begin
      idx <= idx_next;
    end
  end

  // Advance head and count
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      if (cmd.cnt_inc) begin
        count <= count + CNT_W'(1);
        if (cmd.wr_head) begin
          head <= head;
        end
      end else if (cmd.cnt_dec) begin
        count <= count - CNT_W'(1);
        head  <= phys_addr(head, ADDR_W'(1));
      end
    end
  end

  // Record the result, then move it to the output register
  always_ff @(posedge clk) begin
    if (cmd.res_set) begin
      res_status <= cmd.res_status;
      res_data   <= cmd.res_head ? rd_data : '0;
      res_prio   <= cmd.res_head ? rd_prio : '0;
    end
    if (cmd.out_load) begin
      status        <= res_status;
      head_data     <= res_data;
      head_priority <= res_prio;
    end
  end

  assign stat.count_zero = (count == '0);
  assign stat.count_full = (count == CNT_W'(QUEUE_DEPTH));
  assign stat.cmp_le     = ($signed(rd_prio) <= new_prio);
  assign stat.idx_zero   = (idx == '0);

  // A new entry goes only into free room, and only a stored entry leaves
  a_no_inc_full: assert property (@(posedge clk) disable iff (rst)
    cmd.cnt_inc |-> !stat.count_full) else $error("entry added while full");
  a_no_dec_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.cnt_dec |-> !stat.count_zero) else $error("entry removed while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH)) else $error("count beyond depth");

endmodule

FILE: sv/sapq_ctrl.sv
// Controller: sequences each operation and the output handshake.
module sapq_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [sapq_pkg::FUNC_W-1:0]    func,
  output logic                           out_valid,
  input  logic                           out_ready,
  input  sapq_pkg::sapq_stat_t           stat,
  output sapq_pkg::sapq_cmd_t            cmd
);
  import sapq_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_CMP   = 3'd2;
  localparam logic [2:0] S_PLACE = 3'd3;
  localparam logic [2:0] S_FRONT = 3'd4;
  localparam logic [2:0] S_RESP  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  // Decode state into datapath commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          case (func)
            FUNC_ENQUEUE: begin
              if (stat.count_full) begin
                cmd.res_set    = 1'b1;
                cmd.res_status = ST_OVERFLOW;
                state_next     = S_RESP;
              end else if (stat.count_zero) begin
                state_next = S_PLACE;
              end else begin
                state_next = S_SCAN;
              end
            end
            FUNC_DEQUEUE: begin
              cmd.res_set    = 1'b1;
              cmd.res_status = stat.count_zero ? ST_UNDERFLOW : ST_OK;
              cmd.cnt_dec    = !stat.count_zero;
              state_next     = S_RESP;
            end
            FUNC_FRONT: begin
              if (stat.count_zero) begin
                cmd.res_set    = 1'b1;
                cmd.res_status = ST_UNDERFLOW;
                state_next     = S_RESP;
              end else begin
                cmd.rd_en   = 1'b1;
                cmd.rd_head = 1'b1;
                state_next  = S_FRONT;
              end
            end
            default: begin
              cmd.res_set    = 1'b1;
              cmd.res_status = ST_OK;
              state_next     = S_RESP;
            end
          endcase
        end
      end
      S_SCAN: begin
        cmd.rd_en  = 1'b1;
        state_next = S_CMP;
      end
      S_CMP: begin
        cmd.wr_en = 1'b1;
        if (stat.cmp_le) begin
          // shift the read entry one place toward the tail
          if (stat.idx_zero) begin
            state_next = S_PLACE;
          end else begin
            cmd.rd_en   = 1'b1;
            cmd.idx_dec = 1'b1;
          end
        end else begin
          // drop the new entry in behind the read entry
          cmd.wr_new     = 1'b1;
          cmd.cnt_inc    = 1'b1;
          cmd.res_set    = 1'b1;
          cmd.res_status = ST_OK;
          state_next     = S_RESP;
        end
      end
      S_PLACE: begin
        cmd.wr_en      = 1'b1;
        cmd.wr_new     = 1'b1;
        cmd.wr_head    = 1'b1;
        cmd.cnt_inc    = 1'b1;
        cmd.res_set    = 1'b1;
        cmd.res_status = ST_OK;
        state_next     = S_RESP;
      end
      S_FRONT: begin
        cmd.res_set    = 1'b1;
        cmd.res_status = ST_OK;
        cmd.res_head   = 1'b1;
        state_next     = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Advance state and track the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Compare step always sees fresh read data
  a_cmp_has_data: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP) |-> $past(cmd.rd_en)) else $error("compare without read");
  // A loaded result shows up at the output
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> out_valid) else $error("result lost");
  // A waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !cmd.out_load) else $error("result overwritten");
  // Read and write never meet on a new item's first cycle
  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !cmd.wr_en) else $error("write while idle");

endmodule
